// ----- hdl/tgc_pkg.sv -----
// Shared types, codes and constants of the touch gesture classifier.
// Used by touch_gesture_classifier; depends on nothing else.
package tgc_pkg;

    localparam int MAX_TOUCHES_DEF = 8;

    localparam int ID_W    = 8;
    localparam int POS_W   = 16;
    localparam int TIME_W  = 32;
    localparam int DIST_W  = 12;
    localparam int MS_W    = 16;
    localparam int GEST_W  = 4;
    localparam int CNT_W   = 4;
    localparam int ALU_W   = 35;

    localparam int IN_DATA_W  = ID_W + 2 * POS_W;
    localparam int OUT_DATA_W = GEST_W + CNT_W;

    localparam logic [DIST_W-1:0] SWIPE_RST  = 12'd50;
    localparam logic [DIST_W-1:0] TAP_RST    = 12'd10;
    localparam logic [MS_W-1:0]   LONG_RST   = 16'd500;
    localparam logic [MS_W-1:0]   DOUBLE_RST = 16'd300;

    typedef enum logic [1:0] {
        ACT_DOWN   = 2'd0,
        ACT_MOTION = 2'd1,
        ACT_UP     = 2'd2,
        ACT_TICK   = 2'd3
    } t_action;

    typedef enum logic [GEST_W-1:0] {
        G_NONE      = 4'd0,
        G_TAP       = 4'd1,
        G_DOUBLE    = 4'd2,
        G_LONG      = 4'd3,
        G_UP        = 4'd4,
        G_DOWN      = 4'd5,
        G_LEFT      = 4'd6,
        G_RIGHT     = 4'd7,
        G_PINCH_IN  = 4'd8,
        G_PINCH_OUT = 4'd9,
        G_THREE     = 4'd10
    } t_gesture;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_SWIPE  = 2'd0,
        REG_TAP    = 2'd1,
        REG_LONG   = 2'd2,
        REG_DOUBLE = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [POS_W-1:0] cur_x;
        logic signed [POS_W-1:0] cur_y;
        logic [TIME_W-1:0]       down_ms;
    } t_slot;

    function automatic logic [ALU_W-1:0] f_sx16(input logic [15:0] v);
        return {{(ALU_W-16){v[15]}}, v};
    endfunction

    function automatic logic [ALU_W-1:0] f_sx17(input logic [16:0] v);
        return {{(ALU_W-17){v[16]}}, v};
    endfunction

    function automatic logic [ALU_W-1:0] f_zx32(input logic [31:0] v);
        return {{(ALU_W-32){1'b0}}, v};
    endfunction

endpackage

// ----- hdl/touch_gesture_classifier.sv -----
// Touch gesture classifier: slot table, shared adder/multiplier and sequencer.
// Depends on tgc_pkg for codes, slot record type and widths.
// One request at a time: the next is taken in the cycle after its result loads, and the
// slot scan (one slot per cycle) and the single shared adder set the pace of each request.
// Reset (i_rst_n low, synchronous) empties the table, clears gesture, clock and tap
// history and loads register defaults.
module touch_gesture_classifier #(
    parameter int MAX_TOUCHES = tgc_pkg::MAX_TOUCHES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] touch_id, [23:8] pos_x, [39:24] pos_y
    input  logic [tgc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [1:0]                     s_axis_tuser,
    // result channel
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [3:0] gesture, [7:4] active_count
    output logic [tgc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] gesture_ready, [2:1] status
    output logic [2:0]                     m_axis_tuser,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [tgc_pkg::MS_W-1:0]       i_cfg_data
);
    import tgc_pkg::*;

    localparam int IW = $clog2(MAX_TOUCHES);
    localparam int CW = $clog2(MAX_TOUCHES + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_DEC, S_RD, S_DX, S_DY, S_ABSX, S_ABSY,
        S_CMPX, S_CMPY, S_WRM, S_SQX, S_SQY, S_SQT, S_SUM, S_CMPD,
        S_HELD, S_CMPL, S_GAP, S_CMPG, S_REL, S_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [DIST_W-1:0] r_swipe;
    logic [DIST_W-1:0] r_tap;
    logic [MS_W-1:0]   r_long;
    logic [MS_W-1:0]   r_double;

    // slot table: valid bits and ids in flops, coordinates and times in memory
    logic [MAX_TOUCHES-1:0] r_slot_valid;
    logic [ID_W-1:0]        r_slot_id [MAX_TOUCHES];
    t_slot                  r_mem [MAX_TOUCHES];
    t_slot                  r_rd;
    logic [CW-1:0]          r_active;

    // global gesture state
    t_gesture          r_held;
    logic [TIME_W-1:0] r_clock;
    logic [TIME_W-1:0] r_last_tap;
    logic              r_tap_seen;

    // current request
    t_action                 r_action;
    logic [ID_W-1:0]         r_id;
    logic signed [POS_W-1:0] r_x;
    logic signed [POS_W-1:0] r_y;

    // scan results
    logic [IW-1:0] r_scan;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic          r_free_ok;
    logic [IW-1:0] r_free_idx;
    logic [IW-1:0] r_slot;

    // working registers of the shared unit
    logic signed [POS_W:0]   r_dx;
    logic signed [POS_W:0]   r_dy;
    logic [POS_W-1:0]        r_adx;
    logic [POS_W-1:0]        r_ady;
    logic [2*POS_W-1:0]      r_sqx;
    logic [2*POS_W-1:0]      r_sqy;
    logic [2*POS_W-1:0]      r_sqt;
    logic [ALU_W-1:0]        r_acc;
    logic [TIME_W-1:0]       r_time;

    // result being built and the output register
    logic              r_res_ready;
    t_gesture          r_res_gest;
    t_status           r_res_status;
    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [2:0]        r_out_user;

    // shared adder/subtractor and squarer
    logic signed [ALU_W-1:0] alu_a;
    logic signed [ALU_W-1:0] alu_b;
    logic signed [ALU_W-1:0] alu_res;
    logic                    alu_sub;
    logic                    alu_neg;
    logic [POS_W-1:0]        mul_a;
    logic [2*POS_W-1:0]      mul_p;

    // memory write port
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_slot         mem_wdata;

    logic [IW-1:0]   dec_slot;
    logic [CW-1:0]   dec_count;
    logic            acc_in;
    logic            out_load;
    logic [CW+3:0]   cnt_ext;

    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign out_load      = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);
    assign cnt_ext       = {4'b0000, r_active};

    // slot chosen on down: the held id first, else the lowest free slot
    assign dec_slot  = r_hit ? r_hit_idx : r_free_idx;
    assign dec_count = r_hit ? r_active : r_active + CW'(1);

    // operand selection for the shared unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        mul_a   = '0;
        case (r_state)
            S_DX: begin
                alu_a = (r_action == ACT_MOTION) ? f_sx16(r_x) : f_sx16(r_rd.cur_x);
                alu_b = f_sx16(r_rd.start_x);
            end
            S_DY: begin
                alu_a = (r_action == ACT_MOTION) ? f_sx16(r_y) : f_sx16(r_rd.cur_y);
                alu_b = f_sx16(r_rd.start_y);
            end
            S_ABSX: begin
                alu_b   = f_sx17(r_dx);
                alu_sub = r_dx[POS_W];
            end
            S_ABSY: begin
                alu_b   = f_sx17(r_dy);
                alu_sub = r_dy[POS_W];
            end
            S_CMPX: begin
                alu_a = ALU_W'(r_swipe);
                alu_b = ALU_W'(r_adx);
            end
            S_CMPY: begin
                alu_a = ALU_W'(r_swipe);
                alu_b = ALU_W'(r_ady);
            end
            S_SQX: mul_a = r_adx;
            S_SQY: mul_a = r_ady;
            S_SQT: mul_a = POS_W'(r_tap);
            S_SUM: begin
                alu_a   = f_zx32(r_sqx);
                alu_b   = f_zx32(r_sqy);
                alu_sub = 1'b0;
            end
            S_CMPD: begin
                alu_a = r_acc;
                alu_b = f_zx32(r_sqt);
            end
            S_HELD: begin
                alu_a = f_zx32(r_clock);
                alu_b = f_zx32(r_rd.down_ms);
            end
            S_CMPL: begin
                alu_a = ALU_W'(r_long);
                alu_b = f_zx32(r_time);
            end
            S_GAP: begin
                alu_a = f_zx32(r_clock);
                alu_b = f_zx32(r_last_tap);
            end
            S_CMPG: begin
                alu_a = f_zx32(r_time);
                alu_b = ALU_W'(r_double);
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_neg = alu_res[ALU_W-1];
    assign mul_p   = mul_a * mul_a;

    // memory write: whole record on down, current position on motion
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = r_rd;
        if (r_state == S_DEC && r_action == ACT_DOWN && (r_hit || r_free_ok)) begin
            mem_we            = 1'b1;
            mem_waddr         = dec_slot;
            mem_wdata.start_x = r_x;
            mem_wdata.start_y = r_y;
            mem_wdata.cur_x   = r_x;
            mem_wdata.cur_y   = r_y;
            mem_wdata.down_ms = r_clock;
        end else if (r_state == S_WRM) begin
            mem_we          = 1'b1;
            mem_wdata.cur_x = r_x;
            mem_wdata.cur_y = r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[r_slot];
    end

    // configuration writes, taken at any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swipe  <= SWIPE_RST;
            r_tap    <= TAP_RST;
            r_long   <= LONG_RST;
            r_double <= DOUBLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_index'(i_cfg_index))
                REG_SWIPE:  r_swipe  <= i_cfg_data[DIST_W-1:0];
                REG_TAP:    r_tap    <= i_cfg_data[DIST_W-1:0];
                REG_LONG:   r_long   <= i_cfg_data;
                REG_DOUBLE: r_double <= i_cfg_data;
                default:    r_swipe  <= r_swipe;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= '0;
            r_active     <= '0;
            r_held       <= G_NONE;
            r_clock      <= '0;
            r_last_tap   <= '0;
            r_tap_seen   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_hit        <= 1'b0;
            r_free_ok    <= 1'b0;
            r_scan       <= '0;
        end else begin
            // drop the taken result unless a new one loads in the same cycle
            if (m_axis_tvalid && m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        r_action     <= t_action'(s_axis_tuser);
                        r_id         <= s_axis_tdata[ID_W-1:0];
                        r_x          <= s_axis_tdata[ID_W+POS_W-1:ID_W];
                        r_y          <= s_axis_tdata[IN_DATA_W-1:ID_W+POS_W];
                        r_res_ready  <= 1'b0;
                        r_res_gest   <= G_NONE;
                        r_res_status <= ST_OK;
                        r_scan       <= '0;
                        r_hit        <= 1'b0;
                        r_free_ok    <= 1'b0;
                        if (t_action'(s_axis_tuser) == ACT_TICK) begin
                            r_clock <= r_clock + TIME_W'(1);
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                // one slot per cycle: note the held id and the lowest free slot
                S_SCAN: begin
                    if (r_slot_valid[r_scan] && r_slot_id[r_scan] == r_id && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_scan;
                    end
                    if (!r_slot_valid[r_scan] && !r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= r_scan;
                    end
                    if (r_scan == IW'(MAX_TOUCHES - 1)) begin
                        r_state <= S_DEC;
                    end else begin
                        r_scan <= r_scan + IW'(1);
                    end
                end
                S_DEC: begin
                    r_slot <= r_hit_idx;
                    if (r_action == ACT_DOWN) begin
                        r_state <= S_OUT;
                        if (r_hit || r_free_ok) begin
                            r_slot_valid[dec_slot] <= 1'b1;
                            r_slot_id[dec_slot]    <= r_id;
                            r_active               <= dec_count;
                            if (dec_count == CW'(2)) begin
                                r_held <= G_PINCH_IN;
                            end else if (dec_count == CW'(3)) begin
                                r_held <= G_THREE;
                            end
                        end else begin
                            r_res_status <= ST_FULL;
                        end
                    end else if (!r_hit) begin
                        r_res_status <= ST_UNKNOWN;
                        r_state      <= S_OUT;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD:   r_state <= S_DX;
                S_DX: begin
                    r_dx    <= alu_res[POS_W:0];
                    r_state <= S_DY;
                end
                S_DY: begin
                    r_dy    <= alu_res[POS_W:0];
                    r_state <= S_ABSX;
                end
                S_ABSX: begin
                    r_adx   <= alu_res[POS_W-1:0];
                    r_state <= S_ABSY;
                end
                S_ABSY: begin
                    r_ady   <= alu_res[POS_W-1:0];
                    r_state <= (r_action == ACT_MOTION) ? S_CMPX : S_SQX;
                end
                // swipe only with a lone finger; x axis wins
                S_CMPX: begin
                    if (r_active == CW'(1) && alu_neg) begin
                        r_held  <= r_dx[POS_W] ? G_LEFT : G_RIGHT;
                        r_state <= S_WRM;
                    end else begin
                        r_state <= S_CMPY;
                    end
                end
                S_CMPY: begin
                    if (r_active == CW'(1) && alu_neg) begin
                        r_held <= r_dy[POS_W] ? G_UP : G_DOWN;
                    end
                    r_state <= S_WRM;
                end
                S_WRM:  r_state <= S_OUT;
                S_SQX: begin
                    r_sqx   <= mul_p;
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sqy   <= mul_p;
                    r_state <= S_SQT;
                end
                S_SQT: begin
                    r_sqt   <= mul_p;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_acc   <= alu_res;
                    r_state <= S_CMPD;
                end
                // squared release distance below squared tap distance: a tap or a long press
                S_CMPD: r_state <= alu_neg ? S_HELD : S_REL;
                S_HELD: begin
                    r_time  <= alu_res[TIME_W-1:0];
                    r_state <= S_CMPL;
                end
                S_CMPL: begin
                    if (alu_neg) begin
                        r_held  <= G_LONG;
                        r_state <= S_REL;
                    end else begin
                        r_state <= S_GAP;
                    end
                end
                S_GAP: begin
                    r_time  <= alu_res[TIME_W-1:0];
                    r_state <= S_CMPG;
                end
                S_CMPG: begin
                    r_held     <= (r_tap_seen && alu_neg) ? G_DOUBLE : G_TAP;
                    r_last_tap <= r_clock;
                    r_tap_seen <= 1'b1;
                    r_state    <= S_REL;
                end
                // report, drop the slot, forget the gesture once all fingers are up
                S_REL: begin
                    r_res_ready          <= 1'b1;
                    r_res_gest           <= r_held;
                    r_slot_valid[r_slot] <= 1'b0;
                    r_active             <= r_active - CW'(1);
                    if (r_active == CW'(1)) begin
                        r_held <= G_NONE;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {cnt_ext[CNT_W-1:0], r_res_gest};
                        r_out_user  <= {r_res_status, r_res_ready};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_slot_valid) == 32'(r_active))
        else $error("active count differs from valid slots");

    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && r_hit) |-> r_slot_valid[r_hit_idx])
        else $error("id match on an empty slot");

    a_full_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && !r_hit && !r_free_ok) |-> r_active == CW'(MAX_TOUCHES))
        else $error("no free slot found with table not full");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && s_axis_tuser == ACT_TICK) |=> r_clock == $past(r_clock) + TIME_W'(1))
        else $error("tick did not advance the clock");

    a_quiet_gesture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tdata[GEST_W-1:0] == G_NONE)
        else $error("gesture reported without release");

endmodule

// ----- tb/touch_gesture_classifier_tb.sv -----
// Self-checking testbench for touch_gesture_classifier: scripted and random touch episodes.
// Every accepted request is scored against a cycle-free gesture predictor kept in this file.
// Depends on tgc_pkg and the touch_gesture_classifier RTL only.
`timescale 1ns / 100ps

module touch_gesture_classifier_tb;
    import tgc_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int SLOTS          = MAX_TOUCHES_DEF;
    localparam int PHASE_REQUESTS = 300;
    localparam int PHASES         = 6;
    localparam int DRAIN_CYCLES   = 2 * SLOTS + 40;

    // One touch request as the generator builds it.
    typedef struct packed {
        t_action            act;
        logic [ID_W-1:0]    id;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } touch_event_t;

    // One gesture report as it appears on the result channel.
    typedef struct {
        logic            ready;
        t_gesture        gesture;
        logic [CNT_W-1:0] active;
        t_status         status;
    } gesture_report_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index = '0;
    logic [MS_W-1:0]       i_cfg_data = '0;

    touch_gesture_classifier u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Gesture predictor state: a private copy of the slot table, the
    // held gesture, the millisecond clock, tap history and the registers.
    // ------------------------------------------------------------------
    logic               slot_used     [SLOTS] = '{default: 1'b0};
    logic [ID_W-1:0]    slot_owner    [SLOTS];
    logic signed [15:0] origin_x      [SLOTS];
    logic signed [15:0] origin_y      [SLOTS];
    logic signed [15:0] now_x         [SLOTS];
    logic signed [15:0] now_y         [SLOTS];
    logic [TIME_W-1:0]  touch_start_ms[SLOTS];
    t_gesture           held_gesture = G_NONE;
    logic [TIME_W-1:0]  ms_clock     = '0;
    logic [TIME_W-1:0]  last_tap_ms  = '0;
    logic               tap_seen     = 1'b0;
    logic [DIST_W-1:0]  swipe_lim    = SWIPE_RST;
    logic [DIST_W-1:0]  tap_lim      = TAP_RST;
    logic [MS_W-1:0]    long_lim     = LONG_RST;
    logic [MS_W-1:0]    dbl_window   = DOUBLE_RST;

    // Requests waiting to be driven, and reports waiting to be seen.
    touch_event_t    touch_script[$];
    gesture_report_t awaited_reports[$];
    logic [ID_W-1:0] loose_ids[$];

    int  requests_queued = 0;
    int  reports_seen    = 0;
    int  mismatches      = 0;
    bit  req_fired       = 1'b0;
    bit  res_fired       = 1'b0;
    bit  steady          = 1'b0;
    int  idle_left       = 0;
    int  stall_left      = 0;

    function automatic logic [CNT_W-1:0] held_count();
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i])
                n = n + 1'b1;
        return n;
    endfunction

    // Apply one request to the predictor state and return the report it yields.
    function automatic gesture_report_t classify_event(touch_event_t ev);
        gesture_report_t  rep;
        int               s;
        longint           dx;
        longint           dy;
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] since_tap;
        rep.ready   = 1'b0;
        rep.gesture = G_NONE;
        rep.status  = ST_OK;
        s = -1;
        if (ev.act != ACT_TICK)
            for (int i = 0; i < SLOTS; i++)
                if (s < 0 && slot_used[i] && slot_owner[i] == ev.id)
                    s = i;
        case (ev.act)
            ACT_DOWN: begin
                // a held id is restarted in place, else take the lowest free slot
                if (s < 0)
                    for (int i = 0; i < SLOTS; i++)
                        if (s < 0 && !slot_used[i])
                            s = i;
                if (s < 0) begin
                    rep.status = ST_FULL;
                end else begin
                    slot_used[s]      = 1'b1;
                    slot_owner[s]     = ev.id;
                    origin_x[s]       = ev.x;
                    origin_y[s]       = ev.y;
                    now_x[s]          = ev.x;
                    now_y[s]          = ev.y;
                    touch_start_ms[s] = ms_clock;
                    if (held_count() == 2)
                        held_gesture = G_PINCH_IN;
                    else if (held_count() == 3)
                        held_gesture = G_THREE;
                end
            end
            ACT_MOTION: begin
                if (s < 0) begin
                    rep.status = ST_UNKNOWN;
                end else begin
                    dx = longint'(ev.x) - longint'(origin_x[s]);
                    dy = longint'(ev.y) - longint'(origin_y[s]);
                    // only a lone finger swipes; x wins over y
                    if (held_count() == 1) begin
                        if ((dx < 0 ? -dx : dx) > longint'(swipe_lim))
                            held_gesture = (dx > 0) ? G_RIGHT : G_LEFT;
                        else if ((dy < 0 ? -dy : dy) > longint'(swipe_lim))
                            held_gesture = (dy > 0) ? G_DOWN : G_UP;
                    end
                    now_x[s] = ev.x;
                    now_y[s] = ev.y;
                end
            end
            ACT_UP: begin
                if (s < 0) begin
                    rep.status = ST_UNKNOWN;
                end else begin
                    dx = longint'(now_x[s]) - longint'(origin_x[s]);
                    dy = longint'(now_y[s]) - longint'(origin_y[s]);
                    // squared distance against squared tap radius
                    if (dx * dx + dy * dy < longint'(tap_lim) * longint'(tap_lim)) begin
                        held = ms_clock - touch_start_ms[s];
                        if (held > long_lim) begin
                            held_gesture = G_LONG;
                        end else begin
                            since_tap = ms_clock - last_tap_ms;
                            if (tap_seen && since_tap < dbl_window)
                                held_gesture = G_DOUBLE;
                            else
                                held_gesture = G_TAP;
                            last_tap_ms = ms_clock;
                            tap_seen    = 1'b1;
                        end
                    end
                    rep.ready    = 1'b1;
                    rep.gesture  = held_gesture;
                    slot_used[s] = 1'b0;
                    if (held_count() == 0)
                        held_gesture = G_NONE;
                end
            end
            default: begin
                ms_clock = ms_clock + 1'b1;
            end
        endcase
        rep.active = held_count();
        return rep;
    endfunction

    task automatic add_event(t_action act, logic [ID_W-1:0] id, logic [15:0] x,
                             logic [15:0] y);
        touch_event_t ev;
        ev.act = act;
        ev.id  = id;
        ev.x   = x;
        ev.y   = y;
        touch_script.push_back(ev);
        requests_queued++;
    endtask

    // ------------------------------------------------------------------
    // Request driver: advance to the next request once the current one is
    // taken, holding off for a drawn number of idle cycles in between.
    // Steady stretches switch idling off on both sides for a while.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        touch_event_t ev;
        if (i_rst_n && (!s_axis_tvalid || req_fired)) begin
            if (idle_left > 0) begin
                s_axis_tvalid <= 1'b0;
                idle_left     <= idle_left - 1;
            end else if (touch_script.size() != 0) begin
                ev = touch_script.pop_front();
                s_axis_tdata  <= {ev.y, ev.x, ev.id};
                s_axis_tuser  <= ev.act;
                s_axis_tvalid <= 1'b1;
                idle_left     <= steady ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 63) == 0)
                    steady <= !steady;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure: drop ready for a drawn stall after each report.
    always @(negedge i_clk) begin
        int stall;
        if (i_rst_n) begin
            stall = res_fired ? (steady ? 0 : $urandom_range(0, 7)) : stall_left;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: track register writes, predict each taken request, and
    // score each report against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        gesture_report_t want;
        gesture_report_t got;
        touch_event_t    ev;
        if (!i_rst_n) begin
            req_fired <= 1'b0;
            res_fired <= 1'b0;
        end else begin
            req_fired <= s_axis_tvalid && s_axis_tready;
            res_fired <= m_axis_tvalid && m_axis_tready;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg_index'(i_cfg_index))
                    REG_SWIPE:  swipe_lim  = i_cfg_data[DIST_W-1:0];
                    REG_TAP:    tap_lim    = i_cfg_data[DIST_W-1:0];
                    REG_LONG:   long_lim   = i_cfg_data;
                    REG_DOUBLE: dbl_window = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                ev.act = t_action'(s_axis_tuser);
                ev.id  = s_axis_tdata[7:0];
                ev.x   = s_axis_tdata[23:8];
                ev.y   = s_axis_tdata[39:24];
                awaited_reports.push_back(classify_event(ev));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                reports_seen++;
                got.ready   = m_axis_tuser[0];
                got.status  = t_status'(m_axis_tuser[2:1]);
                got.gesture = t_gesture'(m_axis_tdata[3:0]);
                got.active  = m_axis_tdata[7:4];
                if (awaited_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: report with nothing awaited: ready=%0d gesture=%0d "
                                 , $realtime, got.ready, got.gesture,
                                 "count=%0d status=%0d", got.active, got.status);
                end else begin
                    want = awaited_reports.pop_front();
                    if (got.ready !== want.ready || got.gesture !== want.gesture ||
                        got.active !== want.active || got.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: report #%0d ready %0d/%0d gesture %0d/%0d ",
                                     $realtime, reports_seen, want.ready, got.ready,
                                     want.gesture, got.gesture,
                                     "count %0d/%0d status %0d/%0d (expected/actual)",
                                     want.active, got.active, want.status, got.status);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: a scripted pass on reset values, then random phases, each
    // opened by a full register write while the block is idle.
    // ------------------------------------------------------------------
    initial begin
        logic [MS_W-1:0] reg_plan [4];
        logic [ID_W-1:0] finger [9];
        logic [ID_W-1:0] id;
        logic [15:0]     x0;
        logic [15:0]     y0;
        int              phase_start;
        int              nf;
        int              nm;
        int              spread;
        int              first;
        int              base;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // scripted pass under reset register values
        add_event(ACT_TICK, 8'h00, 16'h0000, 16'h0000);
        // first tap after reset is plain; a quick second one is a double tap
        add_event(ACT_DOWN, 8'hFF, 16'h8000, 16'h7FFF);
        add_event(ACT_UP,   8'hFF, 16'h0000, 16'h0000);
        add_event(ACT_DOWN, 8'h00, 16'h7FFF, 16'h8000);
        add_event(ACT_UP,   8'h00, 16'hFFFF, 16'hFFFF);
        // motion and release of an id that is not held
        add_event(ACT_MOTION, 8'h05, 16'h1234, 16'h4321);
        add_event(ACT_UP,     8'h05, 16'h0000, 16'h0000);
        // lone finger swipes right, then left, then up on y
        add_event(ACT_DOWN,   8'h01, 16'h0000, 16'h0000);
        add_event(ACT_MOTION, 8'h01, 16'd51, 16'h0000);
        add_event(ACT_MOTION, 8'h01, 16'hFFCD, 16'h0000);
        add_event(ACT_MOTION, 8'h01, 16'h0000, 16'hFFC4);
        add_event(ACT_UP,     8'h01, 16'h0000, 16'h0000);
        // fill the table: pinch at two, three-finger from three on
        for (int k = 0; k < SLOTS; k++)
            add_event(ACT_DOWN, 8'h10 + 8'(k), 16'(k * 7), 16'(k * 3));
        // restart a held id in place, then hit the full table
        add_event(ACT_DOWN, 8'h10, 16'd5, 16'd5);
        add_event(ACT_DOWN, 8'h20, 16'd0, 16'd0);
        for (int k = 0; k < SLOTS; k++)
            add_event(ACT_UP, 8'h10 + 8'(k), 16'h0000, 16'h0000);

        for (int p = 0; p < PHASES; p++) begin
            while (reports_seen != requests_queued)
                @(negedge i_clk);
            case (p)
                0: reg_plan = '{16'd0, 16'd0, 16'd0, 16'd0};
                1: reg_plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                2: reg_plan = '{16'd20, 16'd8, 16'd6, 16'd10};
                3: reg_plan = '{16'($urandom_range(0, 200)), 16'($urandom_range(0, 40)),
                                16'($urandom_range(0, 20)), 16'($urandom_range(0, 30))};
                4: reg_plan = '{16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom)};
                default: reg_plan = '{16'd1, 16'd1, 16'd1, 16'd1};
            endcase
            // write every register back to back, then drop valid
            for (int r = 0; r < 4; r++) begin
                @(negedge i_clk);
                i_cfg_valid <= 1'b1;
                i_cfg_index <= r[1:0];
                i_cfg_data  <= reg_plan[r];
                do @(posedge i_clk); while (!o_cfg_ready);
            end
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;

            phase_start = requests_queued;
            while (requests_queued - phase_start < PHASE_REQUESTS) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        // one finger: down, a few wiggles or drags, hold, release
                        id = 8'($urandom);
                        x0 = 16'($urandom);
                        y0 = 16'($urandom);
                        case ($urandom_range(0, 3))
                            0: spread = 2;
                            1: spread = 12;
                            2: spread = 80;
                            default: spread = 4000;
                        endcase
                        add_event(ACT_DOWN, id, x0, y0);
                        nm = $urandom_range(0, 4);
                        for (int k = 0; k < nm; k++) begin
                            repeat ($urandom_range(0, 3))
                                add_event(ACT_TICK, 8'($urandom), 16'($urandom),
                                          16'($urandom));
                            add_event(ACT_MOTION, id,
                                      16'(int'(x0) + $urandom_range(0, 2 * spread) - spread),
                                      16'(int'(y0) + $urandom_range(0, 2 * spread) - spread));
                        end
                        repeat ($urandom_range(0, 10))
                            add_event(ACT_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
                        add_event(ACT_UP, id, 16'($urandom), 16'($urandom));
                    end
                    5, 6: begin
                        // several fingers, mostly two to four, now and then too many
                        nf = ($urandom_range(0, 7) == 0) ? 9 : $urandom_range(2, 4);
                        base = $urandom_range(0, 255);
                        for (int k = 0; k < nf; k++) begin
                            finger[k] = 8'(base + k);
                            add_event(ACT_DOWN, finger[k], 16'($urandom), 16'($urandom));
                            if ($urandom_range(0, 1))
                                add_event(ACT_TICK, 8'h00, 16'h0000, 16'h0000);
                        end
                        nm = $urandom_range(0, 4);
                        for (int k = 0; k < nm; k++)
                            add_event(ACT_MOTION, finger[$urandom_range(0, nf - 1)],
                                      16'($urandom), 16'($urandom));
                        // release in rotated order; the last finger may still swipe
                        first = $urandom_range(0, nf - 1);
                        for (int k = 0; k < nf; k++) begin
                            add_event(ACT_UP, finger[(first + k) % nf], 16'($urandom),
                                      16'($urandom));
                            if (k == nf - 2 && $urandom_range(0, 1))
                                add_event(ACT_MOTION, finger[(first + nf - 1) % nf],
                                          16'($urandom), 16'($urandom));
                        end
                    end
                    7: begin
                        repeat ($urandom_range(1, 20))
                            add_event(ACT_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
                    end
                    8: begin
                        // noise: any request with any content
                        repeat ($urandom_range(1, 4)) begin
                            id = 8'($urandom);
                            nm = $urandom_range(0, 3);
                            if (t_action'(nm) == ACT_DOWN)
                                loose_ids.push_back(id);
                            add_event(t_action'(nm), id, 16'($urandom), 16'($urandom));
                        end
                    end
                    default: begin
                        // lift whatever the noise left on the panel
                        while (loose_ids.size() != 0)
                            add_event(ACT_UP, loose_ids.pop_front(), 16'($urandom),
                                      16'($urandom));
                    end
                endcase
            end
        end

        while (reports_seen != requests_queued)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: a time limit far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
